@@ src/btpa_pkg.sv @@
`default_nettype none

package btpa_pkg;

	localparam int unsigned POOL_WORDS_DEF = 1024;
	localparam int unsigned WORD_BYTES     = 8;
	localparam int unsigned WORD_SHIFT     = $clog2(WORD_BYTES);

	localparam int unsigned HDR_W = 16;
	localparam int unsigned EXT_W = HDR_W + 2;
	localparam int unsigned CFG_W = 14;
	localparam int unsigned REQ_W = 14;
	localparam int unsigned OFF_W = 13;
	localparam int unsigned BIG_W = 14;

	localparam logic [CFG_W-1:0] POOL_BYTES_RST = 14'd8192;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef logic signed [HDR_W-1:0] hdr_t;
	typedef logic signed [EXT_W-1:0] ext_t;

	localparam hdr_t HDR_MAX   = 16'sh7FFF;
	localparam ext_t HDR_MAX_X = 18'sd32767;
	localparam ext_t WORD_X    = 18'(WORD_BYTES);
	localparam logic [BIG_W-1:0] BIG_MAX = 14'h3FFF;

	// sign-extend a header to the working width
	function automatic ext_t hx(input hdr_t h);
		return $signed({{2{h[HDR_W-1]}}, h});
	endfunction

	// clamp a positive size to what a header can hold
	function automatic hdr_t sat_hdr(input ext_t v);
		hdr_t r;
		if (v > HDR_MAX_X) begin
			r = HDR_MAX;
		end else begin
			r = $signed(v[HDR_W-1:0]);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/btpa_ram.sv @@
`default_nettype none

module btpa_ram #(
	parameter int unsigned WIDTH = btpa_pkg::HDR_W,
	parameter int unsigned DEPTH = btpa_pkg::POOL_WORDS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/boundary_tag_pool_allocator.sv @@
`default_nettype none

// Pool allocator over an implicit list of one-word signed block headers.
// Command channel: drive action, request_bytes and block_offset with start;
// the beat is taken on a rising edge with start high and busy low. busy stays
// high until the command finishes. Exactly one result beat follows each
// command: done is high for one cycle with ok, payload_offset and
// largest_bytes. The receiver cannot stall; a result is simply presented for
// that one cycle, and a new command may be taken in the same cycle.
// Configuration: cfg_we with cfg_wdata writes pool_bytes (used by init);
// write it only while busy is low.
// Sequence: init writes the first header, then the end mark; free reads the
// addressed header and rewrites it as free if it was allocated. Allocate and
// query merge free neighbours, then run the first-fit (or largest) walk; a
// split also writes the remainder header. The single read port of the header
// RAM paces the walks: one header is fetched per cycle, and the next address
// is formed from the header just returned.
// Reset: the pool is unformatted (allocate fails, query reports 0) and
// pool_bytes returns to 8192. Header RAM contents are not cleared; init
// writes the headers that are needed.

module boundary_tag_pool_allocator #(
	parameter int unsigned POOL_WORDS = btpa_pkg::POOL_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [1:0]                    action,
	input  wire logic [btpa_pkg::REQ_W-1:0]    request_bytes,
	input  wire logic [btpa_pkg::OFF_W-1:0]    block_offset,
	output      logic                          done,
	output      logic                          ok,
	output      logic [btpa_pkg::OFF_W-1:0]    payload_offset,
	output      logic [btpa_pkg::BIG_W-1:0]    largest_bytes,
	input  wire logic                          cfg_we,
	input  wire logic [btpa_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int unsigned AW    = $clog2(POOL_WORDS);
	localparam int unsigned IDX_W = $clog2(POOL_WORDS + 1);
	localparam int unsigned SW    = ((IDX_W > 14) ? IDX_W : 14) + 2;
	localparam int unsigned PW    = SW + btpa_pkg::WORD_SHIFT;
	localparam int unsigned SZ_W  = btpa_pkg::REQ_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_HEAD,
		ST_INIT_TAIL,
		ST_FREE_CHECK,
		ST_CO_FIRST,
		ST_CO_STEP,
		ST_WALK_FIRST,
		ST_WALK_STEP,
		ST_SPLIT
	} state_t;

	// word index of the header after the block whose header is h
	function automatic logic [SW-1:0] next_idx(input logic [SW-1:0] idx,
			input btpa_pkg::hdr_t h);
		btpa_pkg::ext_t v;
		v = btpa_pkg::hx(h);
		if (v < 0) begin
			v = -v;
		end
		return idx + SW'(1) + SW'(v[btpa_pkg::EXT_W-1:btpa_pkg::WORD_SHIFT]);
	endfunction

	state_t                     state_q;
	btpa_pkg::action_t          act_q;
	logic [btpa_pkg::CFG_W-1:0] pool_bytes_q;
	logic [IDX_W-1:0]           pwn_q;
	logic [SZ_W-1:0]            size_q;
	logic [AW-1:0]              cur_q;
	logic [AW-1:0]              i_q;
	btpa_pkg::hdr_t             c_q;
	btpa_pkg::hdr_t             s_q;
	btpa_pkg::hdr_t             best_q;
	logic [AW-1:0]              fidx_s1;
	logic                       fend_s1;
	logic                       done_q;
	logic                       ok_q;
	logic [btpa_pkg::OFF_W-1:0] pay_q;
	logic [btpa_pkg::BIG_W-1:0] big_q;

	btpa_pkg::action_t act_in;
	logic              accept;

	logic [SW-1:0]              fetch_idx;
	logic                       fetch_req;
	logic                       fetch_kill;
	logic                       fetch_end;
	logic                       mem_we;
	logic [SW-1:0]              mem_waddr;
	btpa_pkg::hdr_t             mem_wdata;
	logic [btpa_pkg::HDR_W-1:0] ram_rdata;
	logic                       ram_re;

	btpa_pkg::hdr_t  rd_h;
	btpa_pkg::ext_t  rd_x;
	btpa_pkg::ext_t  c_x;
	btpa_pkg::ext_t  s_x;
	btpa_pkg::ext_t  size_x;
	logic            at_end_f;
	logic [SW-1:0]   nxt_f;
	logic            co_stop;
	logic            merge;
	btpa_pkg::hdr_t  csum;
	logic            fit_split;
	logic            fit_whole;
	logic [SW-1:0]   split_addr;
	btpa_pkg::hdr_t  split_val;
	logic [PW-1:0]   pay_w;
	logic [PW-1:0]   head_w;
	btpa_pkg::hdr_t  head_sat;
	logic [SW-1:0]   pwn_x;

	// command decode at the accept edge
	logic [SZ_W-1:0] req_rnd;
	logic [SZ_W-1:0] size_in;
	logic [SW-1:0]   w_raw;
	logic [SW-1:0]   w_clamp;
	logic [SW-1:0]   free_idx;
	logic            free_aligned;

	assign act_in = btpa_pkg::action_t'(action);
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign req_rnd = ((request_bytes == '0) ? SZ_W'(btpa_pkg::WORD_BYTES) : SZ_W'(request_bytes))
		+ SZ_W'(btpa_pkg::WORD_BYTES - 1);
	assign size_in = {req_rnd[SZ_W-1:btpa_pkg::WORD_SHIFT], {btpa_pkg::WORD_SHIFT{1'b0}}};

	assign w_raw = SW'(pool_bytes_q >> btpa_pkg::WORD_SHIFT);
	always_comb begin
		w_clamp = w_raw;
		if (w_raw > SW'(POOL_WORDS)) begin
			w_clamp = SW'(POOL_WORDS);
		end
		if (w_raw < SW'(3)) begin
			w_clamp = SW'(3);
		end
	end

	// an offset of zero wraps to an index beyond the pool
	assign free_idx     = SW'(block_offset >> btpa_pkg::WORD_SHIFT) - SW'(1);
	assign free_aligned = (block_offset[btpa_pkg::WORD_SHIFT-1:0] == '0);

	assign pwn_x    = SW'(pwn_q);
	assign rd_h     = $signed(ram_rdata);
	assign rd_x     = btpa_pkg::hx(rd_h);
	assign c_x      = btpa_pkg::hx(c_q);
	assign s_x      = btpa_pkg::hx(s_q);
	assign size_x   = $signed(btpa_pkg::EXT_W'(size_q));
	assign at_end_f = fend_s1 || (ram_rdata == '0);
	assign nxt_f    = next_idx(SW'(fidx_s1), rd_h);

	// merge pass: stop once the list ends or, for an allocate, the current block is big enough
	assign co_stop = at_end_f || !((act_q == btpa_pkg::ACT_QUERY) || (c_x < size_x));
	assign merge   = (c_x > 0) && (rd_x > 0);
	assign csum    = btpa_pkg::sat_hdr(c_x + rd_x + btpa_pkg::WORD_X);

	// first fit: split when a real remainder is left; take the block whole if one word over or last
	assign fit_split  = s_x > (size_x + btpa_pkg::WORD_X);
	assign fit_whole  = (s_x == (size_x + btpa_pkg::WORD_X)) || ((s_x >= size_x) && at_end_f);
	assign split_addr = SW'(i_q) + SW'(1) + SW'(size_q >> btpa_pkg::WORD_SHIFT);
	assign split_val  = btpa_pkg::sat_hdr(s_x - size_x - btpa_pkg::WORD_X);
	assign pay_w      = PW'(SW'(i_q) + SW'(1)) << btpa_pkg::WORD_SHIFT;

	assign head_w   = PW'(pwn_x - SW'(2)) << btpa_pkg::WORD_SHIFT;
	assign head_sat = (head_w > PW'(32767)) ? btpa_pkg::HDR_MAX
		: $signed(head_w[btpa_pkg::HDR_W-1:0]);

	// RAM access for the current cycle
	always_comb begin
		fetch_req  = 1'b0;
		fetch_idx  = '0;
		fetch_kill = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (act_in)
						btpa_pkg::ACT_ALLOC, btpa_pkg::ACT_QUERY: begin
							fetch_req = 1'b1;
						end
						btpa_pkg::ACT_FREE: begin
							fetch_req  = 1'b1;
							fetch_idx  = free_idx;
							fetch_kill = !free_aligned;
						end
						default: begin
						end
					endcase
				end
			end
			ST_INIT_HEAD: begin
				mem_we    = 1'b1;
				mem_wdata = head_sat;
			end
			ST_INIT_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = pwn_x - SW'(1);
			end
			ST_FREE_CHECK: begin
				if (!fend_s1 && (rd_x < 0)) begin
					mem_we    = 1'b1;
					mem_waddr = SW'(fidx_s1);
					mem_wdata = btpa_pkg::sat_hdr(-rd_x);
				end
			end
			ST_CO_FIRST: begin
				fetch_req = 1'b1;
				fetch_idx = at_end_f ? '0 : nxt_f;
			end
			ST_CO_STEP: begin
				fetch_req = 1'b1;
				fetch_idx = co_stop ? '0 : nxt_f;
				if (!co_stop && merge) begin
					mem_we    = 1'b1;
					mem_waddr = SW'(cur_q);
					mem_wdata = csum;
				end
			end
			ST_WALK_FIRST: begin
				if (!at_end_f) begin
					fetch_req = 1'b1;
					fetch_idx = nxt_f;
				end
			end
			ST_WALK_STEP: begin
				if (act_q == btpa_pkg::ACT_QUERY) begin
					if (!at_end_f) begin
						fetch_req = 1'b1;
						fetch_idx = nxt_f;
					end
				end else if (fit_split) begin
					mem_we    = 1'b1;
					mem_waddr = SW'(i_q);
					mem_wdata = $signed(-size_x[btpa_pkg::HDR_W-1:0]);
				end else if (fit_whole) begin
					mem_we    = 1'b1;
					mem_waddr = SW'(i_q);
					mem_wdata = -s_q;
				end else if (!at_end_f) begin
					fetch_req = 1'b1;
					fetch_idx = nxt_f;
				end
			end
			ST_SPLIT: begin
				if (split_addr < pwn_x) begin
					mem_we    = 1'b1;
					mem_waddr = split_addr;
					mem_wdata = split_val;
				end
			end
			default: begin
			end
		endcase
	end

	// an index at or past the pool end reads as the end mark
	assign fetch_end = fetch_kill || (fetch_idx >= pwn_x);
	assign ram_re    = fetch_req && !fetch_end;

	btpa_ram #(
		.WIDTH(btpa_pkg::HDR_W),
		.DEPTH(POOL_WORDS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr[AW-1:0]),
		.wdata(mem_wdata),
		.re   (ram_re),
		.raddr(fetch_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= btpa_pkg::ACT_INIT;
			pool_bytes_q <= btpa_pkg::POOL_BYTES_RST;
			pwn_q        <= '0;
			fend_s1      <= 1'b1;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				pool_bytes_q <= cfg_wdata;
			end
			// hold the index of the fetch in flight alongside its read
			if (fetch_req) begin
				fidx_s1 <= fetch_idx[AW-1:0];
				fend_s1 <= fetch_end;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q  <= act_in;
						size_q <= size_in;
						best_q <= '0;
						ok_q   <= 1'b1;
						pay_q  <= '0;
						big_q  <= '0;
						unique case (act_in)
							btpa_pkg::ACT_INIT: begin
								pwn_q   <= IDX_W'(w_clamp);
								state_q <= ST_INIT_HEAD;
							end
							btpa_pkg::ACT_FREE: begin
								state_q <= ST_FREE_CHECK;
							end
							default: begin
								state_q <= ST_CO_FIRST;
							end
						endcase
					end
				end
				ST_INIT_HEAD: begin
					state_q <= ST_INIT_TAIL;
				end
				ST_INIT_TAIL, ST_FREE_CHECK: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CO_FIRST: begin
					cur_q   <= fidx_s1;
					c_q     <= rd_h;
					state_q <= at_end_f ? ST_WALK_FIRST : ST_CO_STEP;
				end
				ST_CO_STEP: begin
					if (co_stop) begin
						state_q <= ST_WALK_FIRST;
					end else if (merge) begin
						c_q <= csum;
					end else begin
						// advance: the fetched block becomes the current one
						cur_q <= fidx_s1;
						c_q   <= rd_h;
					end
				end
				ST_WALK_FIRST: begin
					if (at_end_f) begin
						ok_q    <= (act_q == btpa_pkg::ACT_QUERY);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						i_q <= fidx_s1;
						s_q <= rd_h;
						if (rd_x > btpa_pkg::hx(best_q)) begin
							best_q <= rd_h;
						end
						state_q <= ST_WALK_STEP;
					end
				end
				ST_WALK_STEP: begin
					if (act_q == btpa_pkg::ACT_QUERY) begin
						if (at_end_f) begin
							big_q   <= (best_q > $signed(btpa_pkg::HDR_W'(btpa_pkg::BIG_MAX)))
								? btpa_pkg::BIG_MAX : best_q[btpa_pkg::BIG_W-1:0];
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else if (rd_x > btpa_pkg::hx(best_q)) begin
							best_q <= rd_h;
						end
					end else if (fit_split) begin
						pay_q   <= pay_w[btpa_pkg::OFF_W-1:0];
						state_q <= ST_SPLIT;
					end else if (fit_whole) begin
						pay_q   <= pay_w[btpa_pkg::OFF_W-1:0];
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (at_end_f) begin
						ok_q    <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						i_q <= fidx_s1;
						s_q <= rd_h;
					end
				end
				ST_SPLIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign ok             = ok_q;
	assign payload_offset = pay_q;
	assign largest_bytes  = big_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command taken but block not busy next cycle");

	a_write_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr < pwn_x))
		else $error("header write outside the formatted pool");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && ram_re) |-> (mem_waddr[AW-1:0] != fetch_idx[AW-1:0]))
		else $error("header read and write hit the same word in one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in progress");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import btpa_pkg::*;

	// Signed working copies of the package sizes: the walk compares signed
	// headers against sizes, so keep every term of those sums signed.
	localparam int WB           = int'(WORD_BYTES);
	localparam int DEPTH        = int'(POOL_WORDS_DEF);
	localparam int SIZE_CAP     = 32767;
	localparam int BIG_CAP      = 16383;
	localparam int NO_LIMIT     = 32'h7FFF_FFFF;
	localparam int RANDOM_ITEMS = 1370;
	localparam int STALL_LIMIT  = 20000;

	typedef struct {
		logic             ok;
		logic [OFF_W-1:0] payload;
		logic [BIG_W-1:0] biggest;
	} outcome_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       action;
	logic [REQ_W-1:0] request_bytes;
	logic [OFF_W-1:0] block_offset;
	logic             done;
	logic             ok;
	logic [OFF_W-1:0] payload_offset;
	logic [BIG_W-1:0] largest_bytes;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	// Shadow of the allocator: header words, which of them were ever written,
	// the formatted pool length and the pool size register.
	hdr_t             pool_hdr [DEPTH] = '{default: '0};
	bit               hdr_seen [DEPTH];
	int               pool_words = 0;
	logic [CFG_W-1:0] pool_size_reg = POOL_BYTES_RST;

	outcome_t due_outcomes [$];
	int       live_blocks [$];
	int       idle_pct = 0;
	int       err_count = 0;
	int       replies_checked = 0;
	int       n_init = 0;
	int       n_alloc_ok = 0;
	int       n_alloc_fail = 0;
	int       n_free = 0;
	int       n_query = 0;
	int       cfg_writes = 0;
	int       quiet_cycles = 0;

	boundary_tag_pool_allocator dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Pool shadow
	// ---------------------------------------------------------------------

	// Read a header as a signed size; words outside the store read as zero.
	function automatic int hdr_rd(input int i);
		int v;
		if (i >= DEPTH) return 0;
		v = pool_hdr[i];
		return v;
	endfunction

	// Headers saturate, and only words of the formatted pool are written.
	function automatic void hdr_wr(input int i, input int v);
		if (v > SIZE_CAP) v = SIZE_CAP;
		if (i < DEPTH && i < pool_words) begin
			pool_hdr[i] = v[15:0];
			hdr_seen[i] = 1'b1;
		end
	endfunction

	function automatic bit at_tail(input int i);
		return i >= pool_words || hdr_rd(i) == 0;
	endfunction

	// Step over one block, clamped to the end of the formatted pool.
	function automatic int nxt_blk(input int i);
		int h, n;
		h = hdr_rd(i);
		if (h < 0) h = -h;
		n = i + 1 + h / WB;
		return n >= pool_words ? pool_words : n;
	endfunction

	// Merge free neighbours from the first block until the current block
	// holds at least want bytes or the list runs out.
	function automatic void merge_free(input int want);
		int cur, nx, c, n;
		cur = 0;
		if (at_tail(0)) return;
		nx = nxt_blk(0);
		while (!at_tail(nx) && hdr_rd(cur) < want) begin
			c = hdr_rd(cur);
			n = hdr_rd(nx);
			if (c > 0 && n > 0) begin
				hdr_wr(cur, c + n + WB);
			end else begin
				cur = nx;
			end
			nx = nxt_blk(nx);
		end
	endfunction

	// Work out the reply to one command and advance the shadow pool.
	function automatic outcome_t pool_outcome(input action_t act,
			input logic [REQ_W-1:0] req_in, input logic [OFF_W-1:0] off_in);
		outcome_t r;
		int w, rq, i, s, nx, o, wi, h, best;
		bit hit;
		r.ok = 1'b1;
		r.payload = '0;
		r.biggest = '0;
		case (act)
			ACT_INIT: begin
				w = pool_size_reg / WB;
				if (w > DEPTH) w = DEPTH;
				if (w < 3) w = 3;
				pool_words = w;
				hdr_wr(0, (w - 2) * WB);
				hdr_wr(w - 1, 0);
			end
			ACT_ALLOC: begin
				rq = req_in;
				if (rq == 0) rq = WB;
				rq = (rq + WB - 1) / WB * WB;
				hit = 1'b0;
				i = 0;
				merge_free(rq);
				while (!hit && !at_tail(i)) begin
					s = hdr_rd(i);
					nx = nxt_blk(i);
					if (s > rq + WB) begin
						hdr_wr(i, -rq);
						hdr_wr(i + 1 + rq / WB, s - rq - WB);
						hit = 1'b1;
					end else if (s == rq + WB || (s >= rq && at_tail(nx))) begin
						// take the whole block: no room for a remainder header
						hdr_wr(i, -s);
						hit = 1'b1;
					end else begin
						i = nx;
					end
				end
				r.ok = hit;
				if (hit) r.payload = OFF_W'((i + 1) * WB);
			end
			ACT_FREE: begin
				o = off_in;
				wi = o / WB;
				if (o % WB == 0 && wi >= 1 && wi - 1 < pool_words) begin
					h = hdr_rd(wi - 1);
					if (h < 0) hdr_wr(wi - 1, -h);
				end
			end
			default: begin
				best = 0;
				i = 0;
				merge_free(NO_LIMIT);
				while (!at_tail(i)) begin
					s = hdr_rd(i);
					if (s > best) best = s;
					i = nxt_blk(i);
				end
				if (best > BIG_CAP) best = BIG_CAP;
				r.biggest = BIG_W'(best);
			end
		endcase
		return r;
	endfunction

	// True where a free at this offset would read a header word that was
	// never written; such a read is outside the block's contract.
	function automatic bit reads_blank(input int o);
		return o % WB == 0 && o / WB >= 1 && o / WB - 1 < pool_words
			&& !hdr_seen[o / WB - 1];
	endfunction

	// ---------------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------------

	// Present one command beat at a falling edge, after a random idle gap,
	// and hold it until a rising edge finds busy low. The reply is predicted
	// at that edge, so the shadow pool always follows the accepted order.
	task automatic issue_cmd(input action_t act, input logic [REQ_W-1:0] rq,
			input logic [OFF_W-1:0] off);
		outcome_t o;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		action = act;
		request_bytes = rq;
		block_offset = off;
		do @(posedge clk); while (busy);
		o = pool_outcome(act, rq, off);
		due_outcomes.push_back(o);
		case (act)
			ACT_INIT: begin
				n_init++;
				live_blocks.delete();
			end
			ACT_ALLOC: begin
				if (o.ok) begin
					n_alloc_ok++;
					live_blocks.push_back(int'(o.payload));
				end else begin
					n_alloc_fail++;
				end
			end
			ACT_FREE: n_free++;
			default: n_query++;
		endcase
	endtask

	// Drop start and wait for every pending reply; every command has one,
	// so a short pause after the last is enough to see the block idle.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (due_outcomes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the pool size register, only ever with the block idle.
	task automatic set_pool_size(input logic [CFG_W-1:0] v);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		pool_size_reg = v;
		cfg_writes++;
	endtask

	// ---------------------------------------------------------------------
	// Reply checking and watchdog
	// ---------------------------------------------------------------------

	// Each done beat is checked against the oldest pending prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (due_outcomes.size() == 0) begin
				err_count++;
				$display("%0t: reply beat with nothing pending: ok=%0d offset=%0d largest=%0d",
					$time, ok, payload_offset, largest_bytes);
			end else begin
				want = due_outcomes.pop_front();
				replies_checked++;
				if (ok !== want.ok) begin
					err_count++;
					$display("%0t: ok expected %0d, got %0d", $time, want.ok, ok);
				end
				if (payload_offset !== want.payload) begin
					err_count++;
					$display("%0t: payload_offset expected %0d, got %0d",
						$time, want.payload, payload_offset);
				end
				if (largest_bytes !== want.biggest) begin
					err_count++;
					$display("%0t: largest_bytes expected %0d, got %0d",
						$time, want.biggest, largest_bytes);
				end
			end
		end
	end

	// Count cycles in which no beat moves either way; give up at the limit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d replies pending",
				$time, STALL_LIMIT, due_outcomes.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Before any init the pool is empty: allocate fails and query gives 0.
	task automatic test_unformatted_pool();
		issue_cmd(ACT_ALLOC, 8, 0);
		issue_cmd(ACT_QUERY, 0, 0);
	endtask

	// A zero size clamps to the three-word pool: a single 8-byte payload.
	// Covers the zero request, the whole last block, refusal, and the bad
	// frees (misaligned, and an offset with no header word before it).
	task automatic test_smallest_pool();
		set_pool_size('0);
		issue_cmd(ACT_INIT, 0, 0);
		issue_cmd(ACT_ALLOC, 0, 0);
		issue_cmd(ACT_ALLOC, 1, 0);
		issue_cmd(ACT_QUERY, 0, 0);
		issue_cmd(ACT_FREE, 0, 8);
		issue_cmd(ACT_QUERY, 0, 0);
		issue_cmd(ACT_FREE, 0, 8191);
		issue_cmd(ACT_FREE, 0, 0);
	endtask

	// Eight-word pool: split, an exact fit skipped because it is not last,
	// a fit one word too big taken whole, a double free, and merging.
	task automatic test_fit_rules();
		set_pool_size(64);
		issue_cmd(ACT_INIT, 0, 0);
		issue_cmd(ACT_ALLOC, 8, 0);
		issue_cmd(ACT_ALLOC, 16, 0);
		issue_cmd(ACT_FREE, 0, 8);
		issue_cmd(ACT_ALLOC, 8, 0);
		issue_cmd(ACT_FREE, 0, 24);
		issue_cmd(ACT_ALLOC, 8, 0);
		issue_cmd(ACT_QUERY, 0, 0);
		issue_cmd(ACT_FREE, 0, 8);
		issue_cmd(ACT_FREE, 0, 24);
		issue_cmd(ACT_FREE, 0, 48);
		issue_cmd(ACT_ALLOC, 40, 0);
	endtask

	// All-ones size clamps to the full store; take it in one piece.
	task automatic test_full_pool();
		set_pool_size('1);
		issue_cmd(ACT_INIT, 0, 0);
		issue_cmd(ACT_QUERY, 0, 0);
		issue_cmd(ACT_ALLOC, 16383, 0);
		issue_cmd(ACT_ALLOC, 8176, 0);
		issue_cmd(ACT_FREE, 0, 8);
	endtask

	// Phases of well-formed traffic on a freshly sized pool: allocations,
	// frees of live blocks and queries, salted with stray frees and re-inits.
	// Idling rotates per phase: none, heavy, light.
	task automatic test_random_traffic();
		int phase_no, sent, n, pick, roll, cap, rq, o, idx;
		phase_no = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase_no % 3)
				0: idle_pct = 0;
				1: idle_pct = 85;
				default: idle_pct = 19;
			endcase
			// mostly small pools keep the header walks short
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				set_pool_size($urandom_range(3, 64) * WB);
			end else if (pick < 80) begin
				set_pool_size($urandom_range(65, 256) * WB);
			end else if (pick < 90) begin
				set_pool_size($urandom_range(257, 1024) * WB);
			end else begin
				set_pool_size($urandom_range(0, 16383));
			end
			issue_cmd(ACT_INIT, $urandom_range(0, 16383), $urandom_range(0, 8191));
			n = $urandom_range(20, 90);
			repeat (n) begin
				cap = (pool_words - 2) * WB;
				roll = $urandom_range(0, 99);
				if (roll < 75 && (roll < 45 || live_blocks.size() == 0)) begin
					case ($urandom_range(0, 9))
						0: rq = $urandom_range(0, 16383);
						1, 2, 3, 4: rq = $urandom_range(0, cap / 4 + WB);
						default: rq = $urandom_range(0, cap / (4 * WB) + 1) * WB;
					endcase
					issue_cmd(ACT_ALLOC, rq, $urandom_range(0, 8191));
				end else if (roll < 75) begin
					idx = $urandom_range(0, live_blocks.size() - 1);
					o = live_blocks[idx];
					live_blocks.delete(idx);
					issue_cmd(ACT_FREE, $urandom_range(0, 16383), o);
				end else if (roll < 83) begin
					issue_cmd(ACT_QUERY, $urandom_range(0, 16383), $urandom_range(0, 8191));
				end else if (roll < 97) begin
					// stray free: any offset, or a word boundary in or just past
					// the pool; never one that would read an unwritten word
					if ($urandom_range(0, 1)) begin
						o = $urandom_range(0, 8191);
					end else begin
						o = ($urandom_range(0, pool_words + 1) * WB) % 8192;
					end
					if (reads_blank(o)) o = o | 1;
					issue_cmd(ACT_FREE, $urandom_range(0, 16383), o);
				end else begin
					issue_cmd(ACT_INIT, $urandom_range(0, 16383), $urandom_range(0, 8191));
				end
			end
			sent += n;
			phase_no++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_INIT;
		request_bytes = '0;
		block_offset = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unformatted_pool();
		test_smallest_pool();
		test_fit_rules();
		test_full_pool();
		test_random_traffic();

		settle();
		repeat (20) @(negedge clk);

		$display("Covered %0d commands: %0d inits, %0d allocations (%0d refused),",
			n_init + n_alloc_ok + n_alloc_fail + n_free + n_query, n_init,
			n_alloc_ok + n_alloc_fail, n_alloc_fail);
		$display("%0d frees, %0d queries; pool size written %0d times; %0d replies compared",
			n_free, n_query, cfg_writes, replies_checked);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ boundary_tag_pool_allocator.f @@
src/btpa_pkg.sv
src/btpa_ram.sv
src/boundary_tag_pool_allocator.sv
tb/sv/testbench.sv
